/* hw/rtl/gpra_pkg.sv */
// Shared types and constants of the guarded page run allocator.
// No dependencies; used by gpra_chain, gpra_ctrl and the top level.
`default_nettype none

package gpra_pkg;

	localparam int NUM_PAGES_DEF   = 1024;
	localparam int GUARD_PAGES_DEF = 2;

	localparam int BYTE_W     = 26;
	localparam int PAGE_W     = 10;
	localparam int END_W      = 11;
	localparam int SHIFT_W    = 5;
	localparam int NEED_W     = 27;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [PAGE_W-1:0]  WIN_FIRST_RST  = 10'd0;
	localparam logic [END_W-1:0]   WIN_END_RST    = 11'd1024;
	localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;

	typedef enum logic [1:0] {
		STATUS_DONE     = 2'd0,
		STATUS_NO_SPACE = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIN_FIRST  = 2'd0,
		CFG_WIN_END    = 2'd1,
		CFG_PAGE_SHIFT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic shift;
		logic wr;
		logic wr_val;
	} ring_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/guarded_page_run_allocator.sv */
// Guarded page run allocator. The used bits of NUM_PAGES pages sit in a ring of cells that
// turns one page per cycle past a single head cell, where the sequencer reads and rewrites
// them. An allocate makes a full first-fit scan turn, then a full marking turn, then loads
// the result word into the output register and raises out_valid; the next request is taken
// once the sequencer is idle again. When no run fits, or the run is empty (no guard pages
// and a zero size), the marking turn is skipped; a zero-size allocate with guard pages still
// takes the marking turn. A free makes one clearing turn before its result word. A new
// request is taken while the previous result still waits in the output register; the one
// after it holds its result and stalls the input until that register empties.
// Depends on gpra_pkg, gpra_ctrl, gpra_chain and gpra_cell.
`default_nettype none

module guarded_page_run_allocator #(
	parameter int NUM_PAGES   = gpra_pkg::NUM_PAGES_DEF,
	parameter int GUARD_PAGES = gpra_pkg::GUARD_PAGES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [gpra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [gpra_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              req_type,
	input  wire  [gpra_pkg::BYTE_W-1:0]      byte_count,
	input  wire  [gpra_pkg::PAGE_W-1:0]      start_page,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [1:0]                       status,
	output logic [gpra_pkg::PAGE_W-1:0]      first_page
);

	gpra_pkg::ring_ctl_t ring_ctl;
	logic                head;

	gpra_ctrl #(
		.NUM_PAGES   (NUM_PAGES),
		.GUARD_PAGES (GUARD_PAGES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.byte_count (byte_count),
		.start_page (start_page),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.first_page (first_page),
		.ring_ctl   (ring_ctl),
		.head       (head)
	);

	gpra_chain #(
		.NUM_PAGES (NUM_PAGES)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.head   (head)
	);

endmodule

`default_nettype wire

/* hw/rtl/gpra_cell.sv */
// One cell of the page bitmap ring: holds the used bit of one page.
// No dependencies.
`default_nettype none

module gpra_cell (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  shift,
	input  wire  d,
	output logic q
);

	logic bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (shift) begin
			bit_q <= d;
		end
	end

	assign q = bit_q;

endmodule

`default_nettype wire

/* hw/rtl/gpra_chain.sv */
// Ring of page cells that rotates one page per cycle past the head while shift is set.
// Depends on gpra_pkg and gpra_cell.
`default_nettype none

module gpra_chain #(
	parameter int NUM_PAGES = gpra_pkg::NUM_PAGES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  gpra_pkg::ring_ctl_t ctl,
	output logic                head
);

	logic [NUM_PAGES-1:0] cell_q;
	logic                 head_new;

	assign head     = cell_q[0];
	assign head_new = ctl.wr ? ctl.wr_val : cell_q[0];

	for (genvar i = 0; i < NUM_PAGES; i++) begin : g_cell
		logic d;
		if (i == NUM_PAGES - 1) begin : g_tail
			assign d = head_new;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		gpra_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ctl.shift),
			.d      (d),
			.q      (cell_q[i])
		);
	end

endmodule

`default_nettype wire

/* hw/rtl/gpra_ctrl.sv */
// Request sequencer: configuration, first-fit scan, mark and free passes, result word.
// Depends on gpra_pkg; drives the ring in gpra_chain.
`default_nettype none

module gpra_ctrl #(
	parameter int NUM_PAGES   = gpra_pkg::NUM_PAGES_DEF,
	parameter int GUARD_PAGES = gpra_pkg::GUARD_PAGES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [gpra_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [gpra_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  req_type,
	input  wire  [gpra_pkg::BYTE_W-1:0]          byte_count,
	input  wire  [gpra_pkg::PAGE_W-1:0]          start_page,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [1:0]                           status,
	output logic [gpra_pkg::PAGE_W-1:0]          first_page,
	output gpra_pkg::ring_ctl_t                  ring_ctl,
	input  wire                                  head
);

	localparam int NW   = gpra_pkg::NEED_W;
	localparam int PW   = $clog2(NUM_PAGES);
	localparam int CW   = PW + 1;
	localparam int SW   = (CW > gpra_pkg::PAGE_W) ? CW : gpra_pkg::PAGE_W;
	localparam int LEAD = GUARD_PAGES / 2;

	localparam logic [NW-1:0] LEAD_N  = NW'(LEAD);
	localparam logic [NW-1:0] GUARD_N = NW'(GUARD_PAGES);
	localparam logic [NW-1:0] PAGES_N = NW'(NUM_PAGES);
	localparam logic [CW-1:0] LAST_P  = CW'(NUM_PAGES - 1);

	function automatic logic [NW-1:0] pages_for(
		input logic [gpra_pkg::BYTE_W-1:0]  b,
		input logic [gpra_pkg::SHIFT_W-1:0] sh
	);
		logic [31:0] w;
		logic [31:0] m;
		w = 32'(b);
		m = ~(32'hFFFF_FFFF << sh);
		return NW'(w >> sh) + NW'(|(w & m));
	endfunction

	gpra_pkg::state_t state_q, state_d;

	logic [gpra_pkg::PAGE_W-1:0]  win_first_q;
	logic [gpra_pkg::END_W-1:0]   win_end_q;
	logic [gpra_pkg::SHIFT_W-1:0] shift_q;

	logic [CW-1:0]               p_q, p_d;
	logic [CW-1:0]               run_q, run_d;
	logic [SW-1:0]               start_q, start_d;
	logic                        found_q, found_d;
	logic                        bad_q, bad_d;
	logic [NW-1:0]               need_q, need_d;
	logic [NW-1:0]               total_q, total_d;
	logic                        type_q, type_d;
	logic [gpra_pkg::PAGE_W-1:0] first_q, first_d;

	logic                        out_valid_q, out_valid_d;
	logic [1:0]                  status_q, status_d;
	logic [gpra_pkg::PAGE_W-1:0] first_page_q, first_page_d;

	logic [NW-1:0] need_in, total_in, lo, end_n, hi, pc, start_n, off, last_n;
	logic [NW-1:0] first_in, last_in;
	logic [CW-1:0] run_inc;
	logic [31:0]   fp_sum;
	logic          in_win, mark_hit, free_hit, last_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_first_q <= gpra_pkg::WIN_FIRST_RST;
			win_end_q   <= gpra_pkg::WIN_END_RST;
			shift_q     <= gpra_pkg::PAGE_SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpra_pkg::CFG_WIN_FIRST:  win_first_q <= cfg_data[gpra_pkg::PAGE_W-1:0];
				gpra_pkg::CFG_WIN_END:    win_end_q   <= cfg_data[gpra_pkg::END_W-1:0];
				gpra_pkg::CFG_PAGE_SHIFT: shift_q     <= cfg_data[gpra_pkg::SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gpra_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q          <= p_d;
		run_q        <= run_d;
		start_q      <= start_d;
		found_q      <= found_d;
		bad_q        <= bad_d;
		need_q       <= need_d;
		total_q      <= total_d;
		type_q       <= type_d;
		first_q      <= first_d;
		status_q     <= status_d;
		first_page_q <= first_page_d;
	end

	assign need_in  = pages_for(byte_count, shift_q);
	assign total_in = need_in + GUARD_N;
	assign lo       = NW'(win_first_q);
	assign end_n    = NW'(win_end_q);
	assign hi       = (end_n > PAGES_N) ? PAGES_N : end_n;
	assign first_in = NW'(start_page);
	assign last_in  = first_in + need_in;

	assign pc        = NW'(p_q);
	assign start_n   = NW'(start_q);
	assign off       = pc - start_n;
	assign last_n    = NW'(first_q) + need_q;
	assign run_inc   = run_q + CW'(1);
	assign in_win    = (pc >= lo) && (pc < hi);
	assign last_step = (p_q == LAST_P);
	assign mark_hit  = found_q && (pc >= start_n) && (off >= LEAD_N) && (off < LEAD_N + need_q);
	assign free_hit  = (need_q != '0) && (pc >= NW'(first_q)) && in_win && (pc < last_n);
	assign fp_sum    = 32'(start_q) + ((total_q != '0) ? 32'(LEAD) : 32'd0);

	always_comb begin
		state_d      = state_q;
		p_d          = p_q;
		run_d        = run_q;
		start_d      = start_q;
		found_d      = found_q;
		bad_d        = bad_q;
		need_d       = need_q;
		total_d      = total_q;
		type_d       = type_q;
		first_d      = first_q;
		out_valid_d  = out_valid_q && out_stall;
		status_d     = status_q;
		first_page_d = first_page_q;
		ring_ctl     = '0;

		unique case (state_q)
			gpra_pkg::ST_IDLE: begin
				if (in_valid) begin
					type_d  = req_type;
					first_d = start_page;
					need_d  = need_in;
					total_d = total_in;
					p_d     = '0;
					run_d   = '0;
					found_d = (total_in == '0);
					start_d = SW'(win_first_q);
					bad_d   = (need_in != '0) && ((first_in < lo) || (last_in > hi));
					state_d = (req_type == gpra_pkg::REQ_FREE) ? gpra_pkg::ST_FREE
						: gpra_pkg::ST_SCAN;
				end
			end
			gpra_pkg::ST_SCAN: begin
				ring_ctl.shift = 1'b1;
				if (!found_q && in_win) begin
					if (head) begin
						run_d = '0;
					end else begin
						if (run_q == '0) begin
							start_d = SW'(p_q);
						end
						run_d = run_inc;
						if (NW'(run_inc) >= total_q) begin
							found_d = 1'b1;
						end
					end
				end
				if (last_step) begin
					p_d     = '0;
					state_d = (found_d && total_q != '0) ? gpra_pkg::ST_MARK
						: gpra_pkg::ST_RESULT;
				end else begin
					p_d = p_q + CW'(1);
				end
			end
			gpra_pkg::ST_MARK: begin
				ring_ctl.shift  = 1'b1;
				ring_ctl.wr     = mark_hit;
				ring_ctl.wr_val = 1'b1;
				if (last_step) begin
					p_d     = '0;
					state_d = gpra_pkg::ST_RESULT;
				end else begin
					p_d = p_q + CW'(1);
				end
			end
			gpra_pkg::ST_FREE: begin
				ring_ctl.shift  = 1'b1;
				ring_ctl.wr     = free_hit;
				ring_ctl.wr_val = 1'b0;
				if (free_hit && !head) begin
					bad_d = 1'b1;
				end
				if (last_step) begin
					p_d     = '0;
					state_d = gpra_pkg::ST_RESULT;
				end else begin
					p_d = p_q + CW'(1);
				end
			end
			gpra_pkg::ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					if (type_q == gpra_pkg::REQ_FREE) begin
						status_d     = bad_q ? gpra_pkg::STATUS_BAD_FREE : gpra_pkg::STATUS_DONE;
						first_page_d = '0;
					end else if (found_q) begin
						status_d     = gpra_pkg::STATUS_DONE;
						first_page_d = fp_sum[gpra_pkg::PAGE_W-1:0];
					end else begin
						status_d     = gpra_pkg::STATUS_NO_SPACE;
						first_page_d = '0;
					end
					state_d = gpra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gpra_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall   = (state_q != gpra_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign first_page = first_page_q;

endmodule

`default_nettype wire

/* verif/tb_guarded_page_run_allocator.sv */
// Self-checking testbench for guarded_page_run_allocator: random and directed allocate and
// free requests, a bitmap predictor of first-fit guarded runs, random input gaps and output stalls.
// Depends on gpra_pkg and the RTL of the allocator.
module tb_guarded_page_run_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGES = gpra_pkg::NUM_PAGES_DEF;
	localparam int GUARDS = gpra_pkg::GUARD_PAGES_DEF;
	localparam int LEAD = GUARDS / 2;
	localparam int BYTE_W = gpra_pkg::BYTE_W;
	localparam int PAGE_W = gpra_pkg::PAGE_W;
	localparam int END_W = gpra_pkg::END_W;
	localparam int SHIFT_W = gpra_pkg::SHIFT_W;
	localparam int CFG_IDX_W = gpra_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = gpra_pkg::CFG_DATA_W;
	localparam longint unsigned BYTE_MAX = (64'd1 << BYTE_W) - 1;
	localparam int TAIL_CYCLES = 2 * PAGES + 64;
	localparam int HOLD_CYCLES = 7 * PAGES;

	typedef struct {
		gpra_pkg::req_t kind;
		logic [BYTE_W-1:0] bytes;
		logic [PAGE_W-1:0] page;
	} request_t;

	typedef struct {
		gpra_pkg::status_t status;
		logic [PAGE_W-1:0] page;
	} grant_t;

	typedef struct {
		logic [PAGE_W-1:0] page;
		longint unsigned pages;
	} held_run_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [BYTE_W-1:0] byte_count = '0;
	logic [PAGE_W-1:0] start_page = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [PAGE_W-1:0] first_page;

	guarded_page_run_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.byte_count(byte_count),
		.start_page(start_page),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.first_page(first_page)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bit page_busy [PAGES];
	logic [PAGE_W-1:0] win_first;
	logic [END_W-1:0] win_end;
	logic [SHIFT_W-1:0] pg_shift;

	request_t pending [$];
	grant_t grants_due [$];
	held_run_t held_runs [$];
	int errors = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	task automatic report(string line);
		$display("mismatch: %s", line);
		errors++;
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic longint unsigned pages_of(logic [BYTE_W-1:0] bytes);
		longint unsigned sz;
		sz = 64'd1 << pg_shift;
		return (longint'(bytes) + sz - 1) >> pg_shift;
	endfunction

	function automatic grant_t apply_request(request_t r);
		grant_t g;
		longint unsigned npages, total, lo, hi, run, base, p, last;
		bit hit, bad;
		npages = pages_of(r.bytes);
		lo = win_first;
		hi = (win_end > PAGES) ? PAGES : win_end;
		g.status = gpra_pkg::STATUS_DONE;
		g.page = '0;
		if (r.kind == gpra_pkg::REQ_ALLOC) begin
			total = npages + GUARDS;
			run = 0;
			base = lo;
			hit = (total == 0);
			for (p = lo; !hit && p < hi; p++) begin
				if (page_busy[p]) begin
					run = 0;
				end else begin
					if (run == 0)
						base = p;
					run++;
					if (run >= total)
						hit = 1'b1;
				end
			end
			if (!hit) begin
				g.status = gpra_pkg::STATUS_NO_SPACE;
			end else begin
				if (total != 0)
					for (p = base + LEAD; p < base + LEAD + npages && p < PAGES; p++)
						page_busy[p] = 1'b1;
				g.page = PAGE_W'(base + ((total != 0) ? LEAD : 0));
			end
		end else begin
			last = longint'(r.page) + npages;
			bad = 1'b0;
			if (npages != 0) begin
				if (r.page < lo || last > hi)
					bad = 1'b1;
				for (p = (r.page < lo) ? lo : r.page; p < last && p < hi; p++) begin
					if (!page_busy[p])
						bad = 1'b1;
					page_busy[p] = 1'b0;
				end
			end
			if (bad)
				g.status = gpra_pkg::STATUS_BAD_FREE;
		end
		return g;
	endfunction

	function automatic logic [BYTE_W-1:0] bytes_for(longint unsigned n);
		longint unsigned b;
		b = n << pg_shift;
		if (n != 0 && pg_shift < BYTE_W)
			b -= $urandom_range(0, (1 << pg_shift) - 1);
		if (b > BYTE_MAX)
			b = BYTE_MAX;
		return b[BYTE_W-1:0];
	endfunction

	function automatic request_t make_request();
		request_t r;
		held_run_t h;
		int pick, idx;
		pick = $urandom_range(0, 99);
		r.page = PAGE_W'($urandom_range(0, PAGES - 1));
		if (pick < 45) begin
			r.kind = gpra_pkg::REQ_ALLOC;
			r.bytes = bytes_for(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
				: $urandom_range(0, 6));
		end else if (pick < 80 && held_runs.size() != 0) begin
			idx = $urandom_range(0, held_runs.size() - 1);
			h = held_runs[idx];
			held_runs.delete(idx);
			r.kind = gpra_pkg::REQ_FREE;
			r.page = h.page;
			r.bytes = bytes_for(h.pages);
		end else begin
			r.kind = $urandom_range(0, 1) ? gpra_pkg::REQ_FREE : gpra_pkg::REQ_ALLOC;
			r.bytes = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, BYTE_MAX))
				: bytes_for($urandom_range(0, 3));
		end
		return r;
	endfunction

	function automatic void queue_req(gpra_pkg::req_t kind, longint unsigned bytes, int page);
		request_t r;
		r.kind = kind;
		r.bytes = BYTE_W'(bytes);
		r.page = PAGE_W'(page);
		pending.push_back(r);
	endfunction

	request_t offered;
	grant_t granted;
	longint unsigned offered_pages;
	bit nxt_valid;
	int send_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			nxt_valid = in_valid;
			if (in_valid && !in_stall) begin
				offered_pages = pages_of(offered.bytes);
				granted = apply_request(offered);
				grants_due.push_back(granted);
				if (offered.kind == gpra_pkg::REQ_ALLOC && granted.status == gpra_pkg::STATUS_DONE
					&& offered_pages != 0)
					held_runs.push_back('{granted.page, offered_pages});
				nxt_valid = 1'b0;
				send_gap = (calm || $urandom_range(0, 1)) ? 0 : pick_gap();
			end
			if (!nxt_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending.size() != 0) begin
					offered = pending.pop_front();
					req_type <= offered.kind;
					byte_count <= offered.bytes;
					start_page <= offered.page;
					nxt_valid = 1'b1;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	grant_t want;
	int stall_left;
	int hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (grants_due.size() == 0) begin
					report($sformatf("word with nothing expected: status %0d page %0d",
						status, first_page));
				end else begin
					want = grants_due.pop_front();
					if (status !== want.status)
						report($sformatf("status got %0d want %0d", status, want.status));
					if (first_page !== want.page)
						report($sformatf("first_page got %0d want %0d", first_page,
							want.page));
				end
			end
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0)
				hold_left--;
			else if (stall_left != 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			out_stall <= (hold_left != 0) || (stall_left != 0);
		end
	end

	task automatic wait_idle();
		@(negedge clk);
		while (pending.size() != 0 || in_valid || grants_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(gpra_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gpra_pkg::CFG_WIN_FIRST: win_first = data[PAGE_W-1:0];
			gpra_pkg::CFG_WIN_END: win_end = data[END_W-1:0];
			gpra_pkg::CFG_PAGE_SHIFT: pg_shift = data[SHIFT_W-1:0];
			default: ;
		endcase
	endtask

	int ph_first [12] = '{0, 0, 1000, 3, 900, 0, 0, 600, 1023, 0, 512, 0};
	int ph_end [12] = '{1024, 1024, 1024, 40, 2047, 1024, 1024, 600, 1024, 1, 0, 1024};
	int ph_shift [12] = '{12, 16, 12, 13, 14, 0, 31, 12, 12, 15, 12, 12};
	int ph_count [12] = '{120, 80, 80, 80, 80, 80, 60, 40, 40, 40, 40, 220};

	initial begin : stimulus
		int ph, n;
		for (n = 0; n < PAGES; n++)
			page_busy[n] = 1'b0;
		win_first = gpra_pkg::WIN_FIRST_RST;
		win_end = gpra_pkg::WIN_END_RST;
		pg_shift = gpra_pkg::PAGE_SHIFT_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		queue_req(gpra_pkg::REQ_ALLOC, 0, 0);
		queue_req(gpra_pkg::REQ_ALLOC, 1, 10'h3FF);
		queue_req(gpra_pkg::REQ_ALLOC, 4096, 0);
		queue_req(gpra_pkg::REQ_ALLOC, 4097, 0);
		queue_req(gpra_pkg::REQ_ALLOC, BYTE_MAX, 0);
		queue_req(gpra_pkg::REQ_FREE, 4096, 1);
		queue_req(gpra_pkg::REQ_FREE, 4096, 1);
		queue_req(gpra_pkg::REQ_FREE, 0, 5);
		queue_req(gpra_pkg::REQ_FREE, 8192, 10'h3FF);
		queue_req(gpra_pkg::REQ_ALLOC, 1022 << 12, 0);
		queue_req(gpra_pkg::REQ_FREE, BYTE_MAX, 0);
		queue_req(gpra_pkg::REQ_ALLOC, 1022 << 12, 0);
		queue_req(gpra_pkg::REQ_ALLOC, 0, 0);
		queue_req(gpra_pkg::REQ_FREE, 1022 << 12, 1);
		queue_req(gpra_pkg::REQ_ALLOC, 1023 << 12, 0);
		queue_req(gpra_pkg::REQ_ALLOC, (3 << 12) + 1, 0);
		wait_idle();

		for (ph = 0; ph < 12; ph++) begin
			write_reg(gpra_pkg::CFG_WIN_FIRST, CFG_DATA_W'(ph_first[ph]));
			write_reg(gpra_pkg::CFG_WIN_END, CFG_DATA_W'(ph_end[ph]));
			write_reg(gpra_pkg::CFG_PAGE_SHIFT, CFG_DATA_W'(ph_shift[ph]));
			calm = (ph == 1);
			for (n = 0; n < ph_count[ph]; n++) begin
				while (pending.size() > 3)
					@(negedge clk);
				if (ph == 0 && n == 20)
					hold_req = 1'b1;
				pending.push_back(make_request());
			end
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#100_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
